// File: sv/packed_int_codec_core_defines.svh
// Assertion macros for the packed integer codec.
// Included by the modules that check their own logic; no other dependencies.
`ifndef PACKED_INT_CODEC_CORE_DEFINES_SVH
`define PACKED_INT_CODEC_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge, off during reset
`define PIC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pic check failed");
// Next-cycle implication
`define PIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pic check failed");
`else
`define PIC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: sv/pic_pkg.sv
// Shared types and constants of the packed integer codec.
// No dependencies; imported by every codec module.
package pic_pkg;

    localparam int VALUE_IN_W  = 32;
    localparam int BYTE_W      = 8;
    localparam int VALUE_OUT_W = 32;
    localparam int GROUP_BITS  = 7;
    localparam int IN_TDATA_W  = 40;   // value_in, byte_in
    localparam int OUT_TDATA_W = 40;   // byte_out, value_out

    // Command word passed from front to back through the queue
    typedef struct packed {
        logic                  is_enc;  // 1: pack value, 0: decode byte
        logic [VALUE_IN_W-1:0] data;    // value, or byte in the low bits
    } t_cmd;

endpackage

// File: sv/packed_int_codec_core.sv
// Packed integer codec, 7-bit groups, low group first, more flag in bit 0.
// An accepted word is held in the queue, then its first result word is registered at the output.
// Throughput: while the output is not stalled, decode takes one byte per cycle and encode
// gives one byte per cycle, ceil(significant bits / 7) bytes for a value, 1 to 5 for 32 bits.
// Reset (synchronous, active low) selects decode, empties the queue, clears the sum.
module packed_int_codec_core #(
    parameter int VALUE_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [pic_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // value_in, byte_in
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [pic_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // byte_out, value_out
    output logic m_axis_tlast
);
    import pic_pkg::*;

    logic q_full;
    logic q_push;
    t_cmd q_in_cmd;
    logic q_pop;
    logic q_valid;
    t_cmd q_out_cmd;

    pic_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (q_in_cmd)
    );

    pic_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    pic_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_out_cmd),
        .o_cmd_pop     (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: sv/pic_front.sv
// Front end of the packed integer codec: mode register and item classification.
// Depends on pic_pkg.
module pic_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [pic_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic              i_q_full,
    output logic              o_q_push,
    output pic_pkg::t_cmd     o_q_cmd
);
    import pic_pkg::*;

    logic r_encode_mode;
    logic n_encode_mode;

    // Take a mode write whenever offered
    assign o_cfg_ready   = 1'b1;
    assign n_encode_mode = i_cfg_valid ? i_cfg_data : r_encode_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encode_mode <= 1'b0;
        end else begin
            r_encode_mode <= n_encode_mode;
        end
    end

    // Accept a word while the queue has room, tag it with the current mode
    assign s_axis_tready = !i_q_full;
    assign o_q_push      = s_axis_tvalid && !i_q_full;

    always_comb begin
        o_q_cmd.is_enc = r_encode_mode;
        if (r_encode_mode) begin
            o_q_cmd.data = s_axis_tdata[VALUE_IN_W-1:0];
        end else begin
            o_q_cmd.data = VALUE_IN_W'(s_axis_tdata[VALUE_IN_W +: BYTE_W]);
        end
    end

endmodule

// File: sv/pic_queue.sv
// Two-entry command queue between codec front and back.
// Depends on pic_pkg.
module pic_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pic_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pic_pkg::t_cmd o_cmd
);
    import pic_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: sv/pic_back.sv
// Back end of the packed integer codec: group serializer, decode accumulator
// and output register. Depends on pic_pkg and packed_int_codec_core_defines.svh.
`include "packed_int_codec_core_defines.svh"

module pic_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  pic_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [pic_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // byte_out, value_out
    output logic          m_axis_tlast
);
    import pic_pkg::*;

    // Only the low 32 bits of a value can reach the ports
    localparam int EW         = (VALUE_BITS < VALUE_IN_W) ? VALUE_BITS : VALUE_IN_W;
    localparam int MAX_GROUPS = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int CW         = $clog2(MAX_GROUPS + 1);

    logic                   r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]      r_byte, n_byte;
    logic [VALUE_OUT_W-1:0] r_value, n_value;
    logic                   r_last, n_last;
    logic                   r_busy, n_busy;
    logic [EW-1:0]          r_rem, n_rem;
    logic [EW-1:0]          r_acc, n_acc;
    logic [CW-1:0]          r_cnt, n_cnt;

    logic                   slot_free;
    logic [EW-1:0]          enc_src;
    logic [EW-1:0]          enc_shift;
    logic                   enc_more;
    logic [GROUP_BITS-1:0]  dec_grp;
    logic [EW-1:0]          dec_ins;
    logic                   dec_room;

    assign slot_free = !r_out_valid || m_axis_tready;

    // Serializer: next group comes from the held remainder or a fresh value
    assign enc_src   = r_busy ? r_rem : i_cmd.data[EW-1:0];
    assign enc_shift = enc_src >> GROUP_BITS;
    assign enc_more  = (enc_shift != '0);

    // Accumulator: drop the group into its slot, bits past the width fall off
    assign dec_grp  = i_cmd.data[BYTE_W-1:1];
    assign dec_room = (r_cnt < CW'(MAX_GROUPS));
    always_comb begin
        dec_ins = r_acc;
        for (int g = 0; g < MAX_GROUPS; g++) begin
            for (int b = 0; b < GROUP_BITS; b++) begin
                if ((g * GROUP_BITS + b < EW) && (r_cnt == CW'(g))) begin
                    dec_ins[g * GROUP_BITS + b] = dec_grp[b];
                end
            end
        end
    end

    // Issue: continue a run, or take the next command when the output slot frees
    always_comb begin
        n_out_valid = r_out_valid;
        n_byte      = r_byte;
        n_value     = r_value;
        n_last      = r_last;
        n_busy      = r_busy;
        n_rem       = r_rem;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        o_cmd_pop   = 1'b0;
        if (slot_free) begin
            n_out_valid = 1'b0;
            priority if (r_busy || (i_cmd_valid && i_cmd.is_enc)) begin
                o_cmd_pop   = !r_busy;
                n_out_valid = 1'b1;
                n_byte      = {enc_src[GROUP_BITS-1:0], enc_more};
                n_value     = '0;
                n_last      = !enc_more;
                n_busy      = enc_more;
                n_rem       = enc_shift;
            end else if (i_cmd_valid) begin
                o_cmd_pop = 1'b1;
                if (i_cmd.data[0]) begin
                    if (dec_room) begin
                        n_acc = dec_ins;
                        n_cnt = r_cnt + CW'(1);
                    end
                end else begin
                    n_out_valid = 1'b1;
                    n_byte      = '0;
                    n_value     = VALUE_OUT_W'(dec_room ? dec_ins : r_acc);
                    n_last      = 1'b1;
                    n_acc       = '0;
                    n_cnt       = '0;
                end
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    // Control state and decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_acc       <= '0;
            r_cnt       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_busy      <= n_busy;
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
        end
    end

    // Output word and remainder
    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_value <= n_value;
        r_last  <= n_last;
        r_rem   <= n_rem;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_value, r_byte};
    assign m_axis_tlast  = r_last;

    `PIC_ASSERT_NOW(a_flag_vs_last, i_clk, i_rst_n, r_out_valid, r_byte[0] != r_last)
    `PIC_ASSERT_NOW(a_busy_has_out, i_clk, i_rst_n, r_busy, r_out_valid)
    `PIC_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_GROUPS))
    `PIC_ASSERT_NEXT(a_enc_emits, i_clk, i_rst_n, slot_free && !r_busy && i_cmd_valid && i_cmd.is_enc, r_out_valid)

endmodule

// File: bench/pic_checker.sv
`timescale 1ns / 100ps
// Result checker for packed_int_codec_core: watches the config, input and result channels.
// Depends on pic_pkg for the word widths; hands its counts to tb_top.
module pic_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic                            i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [pic_pkg::IN_TDATA_W-1:0]  i_in_data,    // value_in, byte_in
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [pic_pkg::OUT_TDATA_W-1:0] i_out_data,   // byte_out, value_out
    input  logic                            i_out_last,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);
    import pic_pkg::*;

    localparam int MAX_GROUPS   = (VALUE_OUT_W + GROUP_BITS - 1) / GROUP_BITS;
    localparam int REPORT_LIMIT = 10;
    localparam int MORE_POS     = 0;

    typedef struct packed {
        logic [BYTE_W-1:0]      byte_out;
        logic [VALUE_OUT_W-1:0] value_out;
        logic                   last;
    } t_codec_word;

    t_codec_word            codec_results_due [$];
    logic                   encode_sel;
    logic [VALUE_OUT_W-1:0] partial_sum;
    logic [2:0]             groups_seen;
    int                     fails;
    int                     checked;

    // Split a value into 7-bit groups, low group first, more flag on all but the last
    task automatic pack_value(input logic [VALUE_IN_W-1:0] value);
        logic [VALUE_IN_W-1:0] rest;
        t_codec_word           w;
        rest = value;
        do begin
            w.byte_out  = {rest[GROUP_BITS-1:0], 1'b0};
            rest        = rest >> GROUP_BITS;
            w.byte_out[MORE_POS] = (rest != '0);
            w.value_out = '0;
            w.last      = (rest == '0);
            codec_results_due.push_back(w);
        end while (rest != '0);
    endtask

    // Add one group into the running sum; a clear more flag delivers the sum
    task automatic unpack_byte(input logic [BYTE_W-1:0] b);
        t_codec_word w;
        if (groups_seen < MAX_GROUPS) begin
            partial_sum = partial_sum
                        + (VALUE_OUT_W'(b[BYTE_W-1:1]) << (GROUP_BITS * groups_seen));
            groups_seen = groups_seen + 3'd1;
        end
        if (!b[MORE_POS]) begin
            w.byte_out  = '0;
            w.value_out = partial_sum;
            w.last      = 1'b1;
            codec_results_due.push_back(w);
            partial_sum = '0;
            groups_seen = '0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_codec_word got;
        t_codec_word want;
        if (!i_rst_n) begin
            codec_results_due.delete();
            encode_sel  = 1'b0;
            partial_sum = '0;
            groups_seen = '0;
            fails       = 0;
            checked     = 0;
        end else begin
            // Track the mode register
            if (i_cfg_valid && i_cfg_ready)
                encode_sel = i_cfg_data;

            // Predict the result words of an accepted input word
            if (i_in_valid && i_in_ready) begin
                if (encode_sel)
                    pack_value(i_in_data[VALUE_IN_W-1:0]);
                else
                    unpack_byte(i_in_data[VALUE_IN_W +: BYTE_W]);
            end

            // Compare an accepted result word with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got.byte_out  = i_out_data[BYTE_W-1:0];
                got.value_out = i_out_data[BYTE_W +: VALUE_OUT_W];
                got.last      = i_out_last;
                checked++;
                if (codec_results_due.size() == 0) begin
                    if (fails < REPORT_LIMIT)
                        $display("mismatch: unexpected word byte %02h value %08h last %0b",
                                 got.byte_out, got.value_out, got.last);
                    fails++;
                end else begin
                    want = codec_results_due.pop_front();
                    if (got.byte_out !== want.byte_out || got.value_out !== want.value_out
                        || got.last !== want.last) begin
                        if (fails < REPORT_LIMIT) begin
                            $display("mismatch: expected byte %02h value %08h last %0b",
                                     want.byte_out, want.value_out, want.last);
                            $display("          got      byte %02h value %08h last %0b",
                                     got.byte_out, got.value_out, got.last);
                        end
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= codec_results_due.size();
        o_checked    <= checked;
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the packed_int_codec_core bench: clock, reset, stimulus, pacing and verdict.
// Depends on pic_pkg, packed_int_codec_core and pic_checker.
module tb_top;
    import pic_pkg::*;

    localparam int         STALL_MAX     = 5;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         PHASES        = 6;
    localparam int         PHASE_WORDS   = 16;
    localparam logic       MODE_DECODE   = 1'b0;
    localparam logic       MODE_ENCODE   = 1'b1;
    localparam logic       MORE          = 1'b1;
    localparam logic       DONE          = 1'b0;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_data      = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;    // value_in, byte_in
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // byte_out, value_out
    logic                   m_axis_tlast;

    int   fail_count;
    int   pending;
    int   checked;
    logic cur_mode    = MODE_DECODE;
    bit   no_idle     = 1'b0;
    int   n_packed    = 0;
    int   n_unpacked  = 0;
    int   rx_wait     = 0;
    int   quiet       = 0;

    logic [BYTE_W-1:0] directed_bytes [17] = '{
        8'h00, 8'hFE,                              // zero, top group alone
        8'h01, 8'h02,                              // 128 over two groups
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h1E,         // all ones over five groups
        8'h03, 8'h03, 8'h03, 8'h03, 8'hFF,         // fifth group spills above bit 31
        8'hFF, 8'h02,                              // groups past the fifth
        8'h81                                      // left open across a mode switch
    };
    logic [VALUE_IN_W-1:0] directed_values [7] = '{
        32'h0000_0000, 32'h0000_007F, 32'h0000_0080, 32'h0FFF_FFFF,
        32'h1000_0000, 32'hFFFF_FFFF, 32'h8000_0000
    };

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    packed_int_codec_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    pic_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, STALL_MAX);
    endfunction

    // Pace the result side: stall a random number of cycles after each word
    always @(posedge clk) begin : rx_pace
        int n;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end else if (m_axis_tready) begin
            if (m_axis_tvalid) begin
                n = draw_gap();
                if (n > 0) begin
                    m_axis_tready <= 1'b0;
                    rx_wait       <= n - 1;
                end
            end
        end else if (rx_wait == 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            rx_wait <= rx_wait - 1;
        end
    end

    // Abort when no word moves on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Offer one input word after a random gap; hold valid when no gap follows
    task automatic push_word(input logic [VALUE_IN_W-1:0] value, input logic [BYTE_W-1:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, value};
        do @(posedge clk); while (!s_axis_tready);
        if (cur_mode == MODE_ENCODE)
            n_packed++;
        else
            n_unpacked++;
    endtask

    task automatic push_value(input logic [VALUE_IN_W-1:0] value);
        push_word(value, BYTE_W'($urandom));
    endtask

    task automatic push_byte(input logic [GROUP_BITS-1:0] grp, input logic more);
        push_word($urandom, {grp, more});
    endtask

    // Drop valid, drain all predicted words, then let the core settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic mode);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_mode   = mode;
    endtask

    initial begin : stimulus
        int len;
        int sent;
        int r;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, overlong runs, a value kept across a mode switch
        set_mode(MODE_DECODE);
        foreach (directed_bytes[k])
            push_word($urandom, directed_bytes[k]);
        set_mode(MODE_ENCODE);
        foreach (directed_values[k])
            push_value(directed_values[k]);
        set_mode(MODE_DECODE);
        push_byte(7'h02, DONE);

        // Random phases, alternating mode
        for (int phase = 0; phase < PHASES; phase++) begin
            set_mode(phase[0] ? MODE_DECODE : MODE_ENCODE);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                no_idle = ($urandom_range(0, 3) == 0);
                if (cur_mode == MODE_ENCODE) begin
                    push_value($urandom >> $urandom_range(0, VALUE_IN_W - 1));
                    sent++;
                end else begin
                    r = $urandom_range(0, 9);
                    if (r >= 8) begin
                        // noise: any byte, flag included
                        push_word($urandom, BYTE_W'($urandom));
                        sent++;
                    end else begin
                        len = (r == 7) ? $urandom_range(6, 8) : $urandom_range(1, 5);
                        for (int k = 0; k < len; k++)
                            push_byte(GROUP_BITS'($urandom), (k != len - 1) ? MORE : DONE);
                        sent += len;
                    end
                end
            end
        end
        no_idle = 1'b0;

        drain();
        $display("tb: ran %0d input words, %0d values packed and %0d bytes unpacked",
                 n_packed + n_unpacked, n_packed, n_unpacked);
        $display("tb: %0d result words checked across both modes, %0d mismatched",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
